### rtl/core/efcc_pkg.sv
// efcc_pkg: shared types, constants and helpers of the frame classifier
// no dependencies; used by every module of the block
package efcc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int SUM_W = 32;

    localparam logic [15:0] ETH_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_ARP     = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP  = 8'h01;
    localparam logic [7:0]  PROTO_TCP   = 8'h06;
    localparam logic [7:0]  PROTO_UDP   = 8'h11;
    localparam logic [7:0]  ICMP_ECHO   = 8'h08;
    localparam logic [15:0] ARP_OP_REQ  = 16'h0001;
    localparam logic [15:0] ARP_OP_REP  = 16'h0002;
    localparam logic [15:0] ALL_ONES    = 16'hFFFF;
    localparam logic [31:0] DHCP_PORTS  = {16'd67, 16'd68};

    // frame summary handed from the front to the back
    typedef struct packed {
        logic              ipv4_pre;
        logic              to_local_ip;
        logic              echo_request;
        logic              arp_request_local;
        logic              arp_reply;
        logic              dhcp_reply_ports;
        logic              udp_pre;
        logic              tcp_pre;
        logic [SUM_W-1:0]  header_sum;
        logic [SUM_W-1:0]  udp_sum;
        logic [SUM_W-1:0]  tcp_sum;
        logic [15:0]       udp_length;
        logic [31:0]       port_pair;
        logic [15:0]       tcp_length;
    } frame_sum_t;

    // queue status seen by the back
    typedef struct packed {
        logic valid;
    } q_ctl_t;

    function automatic logic [15:0] fold16(input logic [SUM_W-1:0] s);
        logic [16:0] a;
        logic [16:0] c;
        a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
        c = {1'b0, a[15:0]} + {16'b0, a[16]};
        return c[15:0];
    endfunction

endpackage

### rtl/core/efcc_if.sv
// efcc_byte_if, efcc_flags_if: valid/ready channels of the classifier
// depends on nothing
interface efcc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface efcc_flags_if;
    logic valid;
    logic ready;
    logic ipv4_ok;
    logic to_local_ip;
    logic echo_request;
    logic arp_request_local;
    logic arp_reply;
    logic udp_ok;
    logic tcp_ok;
    logic dhcp_reply_ports;
    modport source (output valid, ipv4_ok, to_local_ip, echo_request, arp_request_local,
                    arp_reply, udp_ok, tcp_ok, dhcp_reply_ports, input ready);
    modport sink   (input valid, ipv4_ok, to_local_ip, echo_request, arp_request_local,
                    arp_reply, udp_ok, tcp_ok, dhcp_reply_ports, output ready);
endinterface

### rtl/core/ethernet_frame_classifier_checksum.sv
// ethernet_frame_classifier_checksum: top level of the frame classifier
// depends on efcc_pkg, efcc_if, efcc_front, efcc_queue, efcc_back
//
// takes one received ethernet frame byte per cycle on rx (destination mac
// onward, last_byte on the final byte) and gives one flag word on res per
// frame: ipv4 header checksum good, destination is local_ip, icmp echo
// request, arp request for local_ip, arp reply, udp and tcp checksums good
// (pseudo-header included, independent of ipv4_ok) and dhcp reply ports.
// rx takes a byte every cycle and stalls only while the two-entry summary
// queue is full; the front keeps running ones'-complement sums as bytes
// stream. the frame summary enters the queue at the edge that takes the
// last byte; the back registers pseudo-header completion in s1 and fold
// and compare in the result register. frames longer than MAX_FRAME_BYTES
// keep their first MAX_FRAME_BYTES bytes. local_ip is written through
// local_ip_wr_en and local_ip_wr_data; the user must write it only while no
// frame is in flight, as the block itself does not enforce this.
module ethernet_frame_classifier_checksum #(
    parameter int MAX_FRAME_BYTES = efcc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          local_ip_wr_en,
    input  logic [31:0]   local_ip_wr_data,
    efcc_byte_if.sink     rx,
    efcc_flags_if.source  res
);
    import efcc_pkg::*;

    logic [31:0] local_ip_reg;
    logic        take;
    logic        push;
    logic        full;
    logic        pop;
    frame_sum_t  wr_entry;
    frame_sum_t  rd_entry;
    q_ctl_t      q_ctl;

    // own address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_ip_reg <= '0;
        else if (local_ip_wr_en)
            local_ip_reg <= local_ip_wr_data;
    end

    // the front only waits when the queue cannot hold another frame
    assign rx.ready = !full;
    assign take     = rx.valid && rx.ready;

    efcc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .frame_byte (rx.frame_byte),
        .last_byte  (rx.last_byte),
        .local_ip   (local_ip_reg),
        .push       (push),
        .entry      (wr_entry)
    );

    efcc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (wr_entry),
        .full      (full),
        .ctl_valid (q_ctl),
        .pop       (pop),
        .rd_entry  (rd_entry)
    );

    efcc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_ctl   (q_ctl),
        .q_entry (rd_entry),
        .pop     (pop),
        .res     (res)
    );

`ifndef ASSERT_OFF
    // a frame summary is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("summary queue overflow");

    // a finished frame is waiting in the queue in the following cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready && rx.last_byte) |=> q_ctl.valid)
        else $error("frame summary lost");

    // udp and tcp need different protocol numbers
    a_l4_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.udp_ok && res.tcp_ok))
        else $error("udp and tcp flags both set");
`endif

endmodule

### rtl/core/efcc_front.sv
// efcc_front: byte parser, field capture and running checksums
// depends on efcc_pkg
module efcc_front #(
    parameter int MAX_FRAME_BYTES = efcc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            frame_byte,
    input  logic                  last_byte,
    input  logic [31:0]           local_ip,
    output logic                  push,
    output efcc_pkg::frame_sum_t  entry
);
    import efcc_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = 18;

    logic [PW-1:0]    pos_reg, pos_next;
    logic [15:0]      ft_reg, ft_next;
    logic [3:0]       hw_reg, hw_next;
    logic [15:0]      tot_reg, tot_next;
    logic [7:0]       proto_reg, proto_next;
    logic [31:0]      dst_reg, dst_next;
    logic [SUM_W-1:0] hs_reg, hs_next;
    logic [SUM_W-1:0] us_reg, us_next;
    logic [SUM_W-1:0] ts_reg, ts_next;
    logic [15:0]      ul_reg, ul_next;
    logic [31:0]      pp_reg, pp_next;
    logic [7:0]       icmp_reg, icmp_next;
    logic [15:0]      op_reg, op_next;
    logic [31:0]      tgt_reg, tgt_next;

    logic             live;
    logic [CW-1:0]    pe, ne, se, ke;
    logic [SUM_W-1:0] w;
    logic [15:0]      tl;
    logic             l4_byte;
    logic             have_ihl, l4;

    always_comb
    begin
        live = take && (pos_reg < PW'(MAX_FRAME_BYTES));
        pe   = CW'(pos_reg);
        w    = pos_reg[0] ? SUM_W'(frame_byte) : SUM_W'({frame_byte, 8'h00});

        ft_next = ft_reg; hw_next = hw_reg; tot_next = tot_reg; proto_next = proto_reg;
        dst_next = dst_reg; hs_next = hs_reg; us_next = us_reg; ts_next = ts_reg;
        ul_next = ul_reg; pp_next = pp_reg; icmp_next = icmp_reg; op_next = op_reg;
        tgt_next = tgt_reg;

        if (live && pe == 18'd14)
            hw_next = frame_byte[3:0];
        se = CW'(14) + CW'({hw_next, 2'b00});
        ke = pe - se;
        tl = 16'(tot_reg - {10'b0, hw_reg, 2'b00});
        l4_byte = live && pe >= 18'd15 && hw_next >= 4'd5 && pe >= se;

        if (live)
        begin
            if (pe == 18'd12 || pe == 18'd13) ft_next = {ft_reg[7:0], frame_byte};
            if (pe == 18'd16 || pe == 18'd17) tot_next = {tot_reg[7:0], frame_byte};
            if (pe == 18'd20 || pe == 18'd21) op_next = {op_reg[7:0], frame_byte};
            if (pe == 18'd23) proto_next = frame_byte;
            if (pe >= 18'd30 && pe <= 18'd33) dst_next = {dst_reg[23:0], frame_byte};
            if (pe >= 18'd38 && pe <= 18'd41) tgt_next = {tgt_reg[23:0], frame_byte};
            if (pe >= 18'd14 && pe < se) hs_next = hs_reg + w;
            // pseudo-header addresses
            if (pe >= 18'd26 && pe <= 18'd33)
            begin
                us_next = us_reg + w;
                ts_next = ts_reg + w;
            end
        end

        if (l4_byte)
        begin
            if (ke == 18'd0) icmp_next = frame_byte;
            if (ke <= 18'd3) pp_next = {pp_reg[23:0], frame_byte};
            if (ke == 18'd4 || ke == 18'd5) ul_next = {ul_reg[7:0], frame_byte};
            if (ke >= 18'd6 && ke < CW'(ul_reg)) us_next = us_reg + w;
            if (ke < CW'(tl)) ts_next = ts_reg + w;
        end

        pos_next = live ? pos_reg + PW'(1) : pos_reg;
        ne       = CW'(pos_next);
        have_ihl = ne >= 18'd15;
        l4       = have_ihl && hw_next >= 4'd5;

        entry.ipv4_pre          = ft_next == ETH_IPV4 && have_ihl && ne >= se;
        entry.to_local_ip       = ne >= 18'd34 && dst_next == local_ip;
        entry.echo_request      = l4 && ne >= se + 18'd1 && proto_next == PROTO_ICMP
                                  && icmp_next == ICMP_ECHO;
        entry.arp_request_local = ft_next == ETH_ARP && ne >= 18'd42 && tgt_next == local_ip
                                  && op_next == ARP_OP_REQ;
        entry.arp_reply         = ft_next == ETH_ARP && ne >= 18'd22 && op_next == ARP_OP_REP;
        entry.dhcp_reply_ports  = l4 && ne >= se + 18'd4 && pp_next == DHCP_PORTS;
        entry.tcp_length        = 16'(tot_next - {10'b0, hw_next, 2'b00});
        entry.udp_pre           = l4 && proto_next == PROTO_UDP && ne >= se + 18'd6
                                  && ne >= se + CW'(ul_next);
        entry.tcp_pre           = l4 && proto_next == PROTO_TCP
                                  && ne >= se + CW'(entry.tcp_length);
        entry.header_sum        = hs_next;
        entry.udp_sum           = us_next;
        entry.tcp_sum           = ts_next;
        entry.udp_length        = ul_next;
        entry.port_pair         = pp_next;

        push = take && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; ft_reg <= '0; hw_reg <= '0; tot_reg <= '0; proto_reg <= '0;
            dst_reg <= '0; hs_reg <= '0; us_reg <= '0; ts_reg <= '0; ul_reg <= '0;
            pp_reg <= '0; icmp_reg <= '0; op_reg <= '0; tgt_reg <= '0;
        end
        else if (push)
        begin
            pos_reg <= '0; ft_reg <= '0; hw_reg <= '0; tot_reg <= '0; proto_reg <= '0;
            dst_reg <= '0; hs_reg <= '0; us_reg <= '0; ts_reg <= '0; ul_reg <= '0;
            pp_reg <= '0; icmp_reg <= '0; op_reg <= '0; tgt_reg <= '0;
        end
        else if (take)
        begin
            pos_reg <= pos_next; ft_reg <= ft_next; hw_reg <= hw_next; tot_reg <= tot_next;
            proto_reg <= proto_next; dst_reg <= dst_next; hs_reg <= hs_next;
            us_reg <= us_next; ts_reg <= ts_next; ul_reg <= ul_next; pp_reg <= pp_next;
            icmp_reg <= icmp_next; op_reg <= op_next; tgt_reg <= tgt_next;
        end
    end

endmodule

### rtl/core/efcc_queue.sv
// efcc_queue: two-entry queue of frame summaries between front and back
// depends on efcc_pkg
module efcc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  efcc_pkg::frame_sum_t  wr_entry,
    output logic                  full,
    output efcc_pkg::q_ctl_t      ctl_valid,
    input  logic                  pop,
    output efcc_pkg::frame_sum_t  rd_entry
);
    import efcc_pkg::*;

    frame_sum_t  mem_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        full            = cnt_reg == 2'd2;
        ctl_valid.valid = cnt_reg != 2'd0;
        rd_entry        = mem_reg[rp_reg];
        wp_next         = push ? ~wp_reg : wp_reg;
        rp_next         = pop ? ~rp_reg : rp_reg;
        cnt_next        = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/efcc_back.sv
// efcc_back: pseudo-header completion, checksum folding and result register
// depends on efcc_pkg and efcc_if
module efcc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  efcc_pkg::q_ctl_t      q_ctl,
    input  efcc_pkg::frame_sum_t  q_entry,
    output logic                  pop,
    efcc_flags_if.source          res
);
    import efcc_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_flags_reg;
    logic [SUM_W-1:0] s1_hs_reg, s1_us_reg, s1_ts_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_reg;
    logic             out_free, s1_go, s1_take;
    logic [SUM_W-1:0] us_tot, ts_tot;
    logic [15:0]      ul;
    logic [31:0]      pp;

    always_comb
    begin
        out_free = !out_valid_reg || res.ready;
        s1_go    = s1_valid_reg && out_free;
        s1_take  = !s1_valid_reg || s1_go;
        pop      = q_ctl.valid && s1_take;
        ul       = q_entry.udp_length;
        pp       = q_entry.port_pair;
        // pseudo-header protocol and length, plus udp header words that were captured rather than summed
        us_tot = q_entry.udp_sum + SUM_W'(PROTO_UDP) + SUM_W'(ul)
               + ((ul > 16'd0) ? SUM_W'({pp[31:24], 8'h00}) : '0)
               + ((ul > 16'd1) ? SUM_W'(pp[23:16]) : '0)
               + ((ul > 16'd2) ? SUM_W'({pp[15:8], 8'h00}) : '0)
               + ((ul > 16'd3) ? SUM_W'(pp[7:0]) : '0)
               + ((ul > 16'd4) ? SUM_W'({ul[15:8], 8'h00}) : '0)
               + ((ul > 16'd5) ? SUM_W'(ul[7:0]) : '0);
        ts_tot = q_entry.tcp_sum + SUM_W'(PROTO_TCP) + SUM_W'(q_entry.tcp_length);
        s1_valid_next  = s1_take ? q_ctl.valid : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_flags_reg <= {q_entry.ipv4_pre, q_entry.to_local_ip, q_entry.echo_request,
                             q_entry.arp_request_local, q_entry.arp_reply,
                             q_entry.udp_pre, q_entry.tcp_pre, q_entry.dhcp_reply_ports};
            s1_hs_reg <= q_entry.header_sum;
            s1_us_reg <= us_tot;
            s1_ts_reg <= ts_tot;
        end
        if (s1_go)
        begin
            out_reg <= {s1_flags_reg[7] && fold16(s1_hs_reg) == ALL_ONES,
                        s1_flags_reg[6:3],
                        s1_flags_reg[2] && fold16(s1_us_reg) == ALL_ONES,
                        s1_flags_reg[1] && fold16(s1_ts_reg) == ALL_ONES,
                        s1_flags_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.ipv4_ok           = out_reg[7];
    assign res.to_local_ip       = out_reg[6];
    assign res.echo_request      = out_reg[5];
    assign res.arp_request_local = out_reg[4];
    assign res.arp_reply         = out_reg[3];
    assign res.udp_ok            = out_reg[2];
    assign res.tcp_ok            = out_reg[1];
    assign res.dhcp_reply_ports  = out_reg[0];

endmodule
